// File: hdl/lphm_pkg.sv
package lphm_pkg;

	// hash multiplier
	localparam logic [63:0] HASH_MULT = 64'hff51afd7ed558ccd;

	// request operations
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// result status codes
	localparam logic [2:0] ST_HIT      = 3'd0;
	localparam logic [2:0] ST_MISS     = 3'd1;
	localparam logic [2:0] ST_INSERTED = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_INVALID  = 3'd4;

	// depth of the job queue between front and back
	localparam int Q_DEPTH = 2;

	// job handed from the front to the back
	typedef struct packed {
		logic        op;
		logic [63:0] key;
		logic [63:0] value;
		logic [31:0] hash;
		logic        bad;
	} job_t;

	// back status seen by the front
	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

// File: hdl/lphm_if.sv
interface lphm_req_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [63:0] key;
	logic [63:0] value_in;

	modport source (output valid, output op, output key, output value_in, input ready);
	modport sink (input valid, input op, input key, input value_in, output ready);
endinterface

interface lphm_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] value_out;

	modport source (output valid, output status, output value_out, input ready);
	modport sink (input valid, input status, input value_out, output ready);
endinterface

// File: hdl/lphm_front.sv
module lphm_front (
	input  logic               clk,
	input  logic               arst_n,
	lphm_req_if.sink           req,
	input  lphm_pkg::back_stat_t stat,
	output logic               job_valid,
	input  logic               job_ready,
	output lphm_pkg::job_t     job
);
	import lphm_pkg::*;

	localparam logic [1:0] STEP_LL   = 2'd0;
	localparam logic [1:0] STEP_HL   = 2'd1;
	localparam logic [1:0] STEP_LH   = 2'd2;
	localparam logic [1:0] STEP_DONE = 2'd3;

	logic        busy_q;
	logic [1:0]  step_q;
	logic        op_q;
	logic [63:0] key_q;
	logic [63:0] val_q;
	logic [31:0] lo_q;
	logic [31:0] hi_q;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic        take;

	assign req.ready = !busy_q && !stat.clearing;
	assign take      = req.valid && req.ready;

	// shared 32x32 multiplier, one partial product per cycle
	assign mul_a = (step_q == STEP_HL) ? key_q[63:32] : key_q[31:0];
	assign mul_b = (step_q == STEP_LH) ? HASH_MULT[63:32] : HASH_MULT[31:0];
	assign prod  = mul_a * mul_b;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_LL;
		end else if (take) begin
			busy_q <= 1'b1;
			step_q <= STEP_LL;
		end else if (busy_q) begin
			if (step_q != STEP_DONE) begin
				step_q <= step_q + 2'd1;
			end else if (job_ready) begin
				busy_q <= 1'b0;
			end
		end
	end

	// payload and hash accumulation
	always_ff @(posedge clk) begin
		if (take) begin
			op_q  <= req.op;
			key_q <= req.key;
			val_q <= req.value_in;
		end else if (busy_q) begin
			case (step_q)
				STEP_LL: begin
					lo_q <= prod[31:0];
					hi_q <= prod[63:32];
				end
				STEP_HL, STEP_LH: begin
					hi_q <= hi_q + prod[31:0];
				end
				default: begin
				end
			endcase
		end
	end

	// classify and hand over
	assign job_valid = busy_q && (step_q == STEP_DONE);
	assign job.op    = op_q;
	assign job.key   = key_q;
	assign job.value = val_q;
	assign job.hash  = lo_q ^ hi_q;
	assign job.bad   = (key_q == 64'd0) || ((op_q == OP_PUT) && (val_q == 64'd0));

endmodule

// File: hdl/lphm_fifo.sv
module lphm_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  lphm_pkg::job_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output lphm_pkg::job_t rd_data
);
	import lphm_pkg::*;

	localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CW = $clog2(Q_DEPTH + 1);

	job_t          mem [Q_DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign wr_ready = (cnt_q != CW'(Q_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(Q_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(Q_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wp_q] <= wr_data;
		end
	end

endmodule

// File: hdl/lphm_back.sv
module lphm_back #(
	parameter int CAPACITY = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  lphm_pkg::job_t     job,
	output lphm_pkg::back_stat_t stat,
	lphm_rsp_if.source         rsp
);
	import lphm_pkg::*;

	localparam int IW   = $clog2(CAPACITY);
	localparam int CNTW = IW + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_CMP  = 2'd2;
	localparam logic [1:0] S_FIN  = 2'd3;

	logic [63:0]   key_mem [CAPACITY];
	logic [63:0]   val_mem [CAPACITY];

	logic [1:0]    state_q;
	logic          clr_q;
	logic [IW-1:0] clr_idx_q;
	logic [CNTW-1:0] cnt_q;
	job_t          job_q;
	logic [IW-1:0] slot_q;
	logic [IW-1:0] probes_q;
	logic [63:0]   rd_key_q;
	logic [63:0]   rd_val_q;
	logic [2:0]    res_status_q;
	logic [63:0]   res_val_q;
	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [63:0]   out_val_q;

	logic          pop;
	logic          trivial;
	logic          out_free;
	logic          hit;
	logic          empty;
	logic          room;
	logic          key_we;
	logic          val_we;
	logic [IW-1:0] key_wa;
	logic [63:0]   key_wd;
	logic [2:0]    cmp_status;
	logic [63:0]   cmp_val;
	logic          cmp_done;

	assign stat.clearing = clr_q;
	assign job_ready     = (state_q == S_IDLE) && !clr_q;
	assign pop           = job_valid && job_ready;
	assign trivial       = job.bad || ((job.op == OP_GET) && (cnt_q == '0));
	assign out_free      = !out_valid_q || rsp.ready;

	// probe compare
	assign hit   = (rd_key_q == job_q.key);
	assign empty = (rd_key_q == 64'd0);
	assign room  = (cnt_q < CNTW'(CAPACITY / 2));

	always_comb begin
		cmp_status = ST_MISS;
		cmp_val    = 64'd0;
		cmp_done   = 1'b1;
		if (hit) begin
			cmp_status = ST_HIT;
			cmp_val    = (job_q.op == OP_GET) ? rd_val_q : 64'd0;
		end else if (empty) begin
			if (job_q.op == OP_GET) begin
				cmp_status = ST_MISS;
			end else begin
				cmp_status = room ? ST_INSERTED : ST_FULL;
			end
		end else if (probes_q == '1) begin
			cmp_status = (job_q.op == OP_GET) ? ST_MISS : ST_FULL;
		end else begin
			cmp_done = 1'b0;
		end
	end

	// memory write port selection
	always_comb begin
		key_we = 1'b0;
		key_wa = slot_q;
		key_wd = job_q.key;
		val_we = 1'b0;
		if (clr_q) begin
			key_we = 1'b1;
			key_wa = clr_idx_q;
			key_wd = 64'd0;
		end else if (state_q == S_CMP && job_q.op == OP_PUT) begin
			if (hit) begin
				val_we = 1'b1;
			end else if (empty && room) begin
				key_we = 1'b1;
				val_we = 1'b1;
			end
		end
	end

	// slot memories with registered read
	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[key_wa] <= key_wd;
		end
		if (state_q == S_READ) begin
			rd_key_q <= key_mem[slot_q];
		end
	end

	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[slot_q] <= job_q.value;
		end
		if (state_q == S_READ) begin
			rd_val_q <= val_mem[slot_q];
		end
	end

	// sequencer, clearing pass and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			cnt_q     <= '0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (clr_idx_q == '1) begin
					clr_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= trivial ? S_FIN : S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					state_q <= cmp_done ? S_FIN : S_READ;
					if (key_we) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// job and result payload
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q        <= job;
			slot_q       <= job.hash[IW-1:0];
			probes_q     <= '0;
			res_status_q <= job.bad ? ST_INVALID : ST_MISS;
			res_val_q    <= 64'd0;
		end else if (state_q == S_CMP) begin
			if (cmp_done) begin
				res_status_q <= cmp_status;
				res_val_q    <= cmp_val;
			end else begin
				slot_q   <= slot_q + 1'b1;
				probes_q <= probes_q + 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FIN && out_free) begin
			out_status_q <= res_status_q;
			out_val_q    <= res_val_q;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.value_out = out_val_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(CAPACITY / 2))
		else $error("entry count above half capacity");

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !job_ready)
		else $error("job taken during clearing pass");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (rsp.valid && state_q == S_IDLE))
		else $error("finished result not presented");

	a_write_in_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		val_we |-> (state_q == S_CMP && !clr_q))
		else $error("value write outside compare");
`endif

endmodule

// File: hdl/linear_probe_hash_map.sv
// open-addressing key/value table with linear probing
// req channel (sink): op (0 get, 1 put), key, value_in; a transfer takes one
// request. rsp channel (source): status and value_out, one per request, in
// request order.
// the front hashes the key with one shared 32x32 multiplier
// and passes the job through a two-entry queue to the back, which walks the
// slots from the start slot; each probed slot takes a registered memory read
// then a compare. the front takes no new request until its job is in the
// queue; the back goes from idle through read and compare to finish for a
// first-slot decision, repeats read and compare per extra probed slot, and
// goes from idle straight to finish on an invalid request or a get on an
// empty table. after reset the back clears every slot of the key memory,
// one slot per cycle; req.ready stays low during that pass.
// a stalled rsp holds its result in the output register; the back stops,
// the queue fills, and then the front stops taking requests.
// CAPACITY must be a power of two from 16 to 65536
module linear_probe_hash_map #(
	parameter int CAPACITY = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	lphm_req_if.sink   req,
	lphm_rsp_if.source rsp
);
	import lphm_pkg::*;

	logic       f_valid;
	logic       f_ready;
	job_t       f_job;
	logic       b_valid;
	logic       b_ready;
	job_t       b_job;
	back_stat_t stat;

	lphm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.stat      (stat),
		.job_valid (f_valid),
		.job_ready (f_ready),
		.job       (f_job)
	);

	lphm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_job),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_job)
	);

	lphm_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (b_valid),
		.job_ready (b_ready),
		.job       (b_job),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule

// File: tb/tb_linear_probe_hash_map.sv
module tb_linear_probe_hash_map;
	import lphm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 1024;

	// expected response of one request
	typedef struct {
		logic [2:0]  status;
		logic [63:0] value_out;
	} lookup_result_t;

	// table model and pending responses
	class table_scoreboard;
		logic [63:0] slot_key [CAP];
		logic [63:0] slot_val [CAP];
		int unsigned occupied;
		lookup_result_t pending[$];
		int unsigned errors;

		function new();
			foreach (slot_key[i]) begin
				slot_key[i] = '0;
				slot_val[i] = '0;
			end
			occupied = 0;
			errors = 0;
		endfunction

		function int unsigned home_slot(logic [63:0] k);
			logic [63:0] h;
			h = k * HASH_MULT;
			h = h ^ (h >> 32);
			return h[31:0] & 32'(CAP - 1);
		endfunction

		// apply one accepted request and queue its response
		function void note_request(logic op, logic [63:0] k, logic [63:0] v);
			lookup_result_t r;
			int unsigned idx;
			int found;
			r.status = ST_MISS;
			r.value_out = '0;
			found = -1;
			if (k == 0 || (op == OP_PUT && v == 0)) begin
				r.status = ST_INVALID;
			end else if (!(op == OP_GET && occupied == 0)) begin
				idx = home_slot(k);
				for (int n = 0; n < CAP; n++) begin
					if (slot_key[idx] == k) begin
						found = 1;
						break;
					end
					if (slot_key[idx] == 0) begin
						found = 0;
						break;
					end
					idx = (idx + 1) & (CAP - 1);
				end
				if (op == OP_GET) begin
					if (found == 1) begin
						r.status = ST_HIT;
						r.value_out = slot_val[idx];
					end
				end else if (found == 1) begin
					slot_val[idx] = v;
					r.status = ST_HIT;
				end else if (found == 0 && 2 * occupied < CAP) begin
					slot_key[idx] = k;
					slot_val[idx] = v;
					occupied++;
					r.status = ST_INSERTED;
				end else begin
					r.status = ST_FULL;
				end
			end
			pending.push_back(r);
		endfunction

		task report(string what);
			errors++;
			$display("error at %0t: %s", $realtime, what);
		endtask

		// compare one response with the oldest pending one
		task check_response(logic [2:0] st, logic [63:0] vo);
			lookup_result_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected response status %0d", st));
			end else begin
				e = pending.pop_front();
				if (st !== e.status)
					report($sformatf("status %0d, want %0d", st, e.status));
				if (vo !== e.value_out)
					report($sformatf("value_out %h, want %h", vo, e.value_out));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	lphm_req_if req ();
	lphm_rsp_if rsp ();

	linear_probe_hash_map #(.CAPACITY(CAP)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	table_scoreboard sb;
	bit calm;
	logic [63:0] used_keys[$];

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		#4ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// response side with random stalls
	initial begin
		int gap;
		rsp.ready = 1'b0;
		gap = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready)
				sb.check_response(rsp.status, rsp.value_out);
			if (gap > 0) begin
				gap--;
				rsp.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 4) - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

	// one request transfer, with an optional random gap first
	task send(logic op, logic [63:0] k, logic [63:0] v);
		int gap;
		if (!calm && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.op <= op;
		req.key <= k;
		req.value_in <= v;
		do @(posedge clk); while (!req.ready);
		sb.note_request(op, k, v);
	endtask

	function logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function logic [63:0] pick_key();
		if (used_keys.size() > 0 && $urandom_range(0, 2) != 0)
			return used_keys[$urandom_range(0, used_keys.size() - 1)];
		pick_key = rand64();
		if ($urandom_range(0, 15) == 0)
			pick_key = pick_key & 64'hff;
		used_keys.push_back(pick_key);
	endfunction

	// wait until every pending response has arrived
	task drain();
		req.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	// stimulus
	initial begin
		logic [63:0] k;
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.op = OP_GET;
		req.key = '0;
		req.value_in = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, invalid inputs, extremes
		send(OP_GET, 64'd5, '1);
		send(OP_GET, '0, '0);
		send(OP_PUT, '0, 64'd1);
		send(OP_PUT, 64'd7, '0);
		send(OP_PUT, '1, '1);
		send(OP_GET, '1, '0);
		send(OP_PUT, 64'd1, 64'd1);
		send(OP_PUT, 64'd1, 64'h8000_0000_0000_0000);
		send(OP_GET, 64'd1, '0);
		send(OP_GET, 64'd2, '0);
		send(OP_PUT, 64'h8000_0000_0000_0000, 64'h5555_aaaa_5555_aaaa);
		send(OP_GET, 64'h8000_0000_0000_0000, '1);
		// pause until idle
		drain();

		// fill to the load limit, then try new keys and updates
		for (int i = 0; i < 520; i++) begin
			k = rand64();
			used_keys.push_back(k);
			send(OP_PUT, k, rand64() | 64'd1);
		end
		for (int i = 0; i < 200; i++)
			send(1'($urandom_range(0, 1)), pick_key(), rand64());
		drain();

		// random mix of gets and puts over known and fresh keys, with occasional zero keys and values
		for (int i = 0; i < 930; i++) begin
			if (i >= 830) calm = 1'b1;
			send(1'($urandom_range(0, 1)), $urandom_range(0, 40) == 0 ? '0 : pick_key(),
				$urandom_range(0, 30) == 0 ? '0 : rand64());
		end
		drain();
		repeat (40) @(posedge clk);

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
